// ===== rtl/prb_pkg.sv =====
// Shared types and constants of the picture reorder bumping block.
`default_nettype none

package prb_pkg;

    localparam int BUFFER_DEPTH_DEF = 16;
    localparam int DEPTH_W          = 5;
    localparam int POC_W            = 32;
    localparam int CNT_W            = 32;
    localparam int S_USER_W         = 3;
    localparam int M_DATA_W         = 2 * CNT_W;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

    // Bit positions of the input flags in s_tuser.
    localparam int USER_OP   = 0;
    localparam int USER_IDR  = 1;
    localparam int USER_DROP = 2;

    typedef enum logic {
        SEL_BEST,
        SEL_NEW
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      scan_start;
        logic      scan_step;
        logic      load_out;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      remove_best;
        logic      append_new;
    } prb_cmd_t;

    typedef struct packed {
        logic in_op;
        logic in_idr;
        logic in_drop;
        logic count_zero;
        logic count_one;
        logic count_ge_eff;
        logic scan_done;
        logic new_less;
        logic out_free;
    } prb_stat_t;

endpackage

`default_nettype wire

// ===== rtl/picture_reorder_bumping.sv =====
// Top level of the picture reorder bumping block: controller plus datapath.
//
// Pictures arrive in decode order on the s_ channel, one per transfer:
// s_tdata carries the POC, s_tuser carries op, is_idr and is_dropped.
// Every picture gets a decode index; dropped pictures give no result.
// Ranked pictures leave on the m_ channel as {display_rank, decode_index},
// with m_tlast set on the final result caused by an input transfer.
// The reorder depth is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, the block itself does not enforce it.
// One item is processed at a time. An item is taken in the idle state and
// classified in the next cycle. A picture that only joins the store passes
// the check state and is appended before the next transfer is taken; a
// dropped picture returns to idle straight after classification. Each
// result takes a check, a scan over every held entry and a load. A
// stalled m_ side holds the result register and the controller waits
// before loading the next one.
// Reset empties the store, clears both counters and sets the depth to sixteen.
`default_nettype none

module picture_reorder_bumping
    import prb_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [POC_W-1:0]    s_tdata,   // [31:0] poc
    input  wire logic [S_USER_W-1:0] s_tuser,   // [0] op, [1] is_idr, [2] is_dropped
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [31:0] decode_index, [63:32] display_rank
    output logic                     m_tlast,
    input  wire logic                cfg_wr_en,
    input  wire logic [DEPTH_W-1:0]  cfg_wr_data
);

    prb_cmd_t  cmd;
    prb_stat_t stat;

    prb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prb_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tready    (m_tready)
    );

    // A result is never loaded over one that has not been transferred.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded over a pending transfer");

    // An entry is only removed from a non-empty store.
    a_remove_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove_best |-> !stat.count_zero)
        else $error("removal from an empty store");

    // A final result shows up on the output in the next cycle with tlast.
    a_last_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && cmd.emit_last) |=> (m_tvalid && m_tlast))
        else $error("final result not presented with tlast");

    // No input is taken while a scan or a store update is under way.
    a_accept_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !(cmd.scan_step || cmd.remove_best || cmd.append_new))
        else $error("input taken during store activity");

endmodule

`default_nettype wire

// ===== rtl/prb_dp.sv =====
// Datapath: held picture store, minimum scan, counters and result register.
`default_nettype none

module prb_dp
    import prb_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [POC_W-1:0]    s_tdata,
    input  wire logic [S_USER_W-1:0] s_tuser,
    input  wire logic                cfg_wr_en,
    input  wire logic [DEPTH_W-1:0]  cfg_wr_data,
    input  wire prb_cmd_t            cmd,
    output prb_stat_t                stat,
    output logic                     m_tvalid,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast,
    input  wire logic                m_tready
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int EW = (CW > DEPTH_W) ? CW : DEPTH_W;

    logic [DEPTH_W-1:0]       depth_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            ptr_reg;
    logic [CNT_W-1:0]         dec_idx_reg;
    logic [CNT_W-1:0]         rank_reg;
    logic                     out_valid_reg;
    logic [CNT_W-1:0]         out_idx_reg;
    logic [CNT_W-1:0]         out_rank_reg;
    logic                     out_last_reg;

    logic signed [POC_W-1:0]  poc_reg [BUFFER_DEPTH];
    logic [CNT_W-1:0]         idx_reg [BUFFER_DEPTH];

    logic                     in_op_reg;
    logic                     in_idr_reg;
    logic                     in_drop_reg;
    logic signed [POC_W-1:0]  in_poc_reg;
    logic [CNT_W-1:0]         in_idx_reg;

    logic signed [POC_W-1:0]  best_poc_reg;
    logic [CNT_W-1:0]         best_idx_reg;
    logic [AW-1:0]            best_pos_reg;

    logic [EW-1:0]            depth_ext;
    logic [EW-1:0]            eff_depth;
    logic [AW-1:0]            rd_addr;
    logic signed [POC_W-1:0]  rd_poc;
    logic [CNT_W-1:0]         rd_idx;

    // Effective depth: zero acts as one, anything above the store size as the size.
    always_comb begin
        depth_ext = EW'(depth_reg);
        priority if (depth_ext == '0) begin
            eff_depth = EW'(1);
        end else if (depth_ext > EW'(BUFFER_DEPTH)) begin
            eff_depth = EW'(BUFFER_DEPTH);
        end else begin
            eff_depth = depth_ext;
        end
    end

    assign rd_addr = ptr_reg[AW-1:0];
    assign rd_poc  = poc_reg[rd_addr];
    assign rd_idx  = idx_reg[rd_addr];

    always_comb begin
        stat.in_op        = in_op_reg;
        stat.in_idr       = in_idr_reg;
        stat.in_drop      = in_drop_reg;
        stat.count_zero   = (count_reg == '0);
        stat.count_one    = (count_reg == CW'(1));
        stat.count_ge_eff = (EW'(count_reg) >= eff_depth);
        stat.scan_done    = (ptr_reg == count_reg);
        stat.new_less     = (in_poc_reg < best_poc_reg);
        stat.out_free     = !out_valid_reg || m_tready;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= DEPTH_RESET;
            count_reg     <= '0;
            ptr_reg       <= '0;
            dec_idx_reg   <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                depth_reg <= cfg_wr_data;
            end
            if (cmd.accept && !s_tuser[USER_OP]) begin
                dec_idx_reg <= dec_idx_reg + 1'b1;
            end
            if (cmd.scan_start) begin
                ptr_reg <= '0;
            end else if (cmd.scan_step) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.remove_best) begin
                count_reg <= count_reg - 1'b1;
            end else if (cmd.append_new) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_out) begin
                rank_reg      <= rank_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_op_reg   <= s_tuser[USER_OP];
            in_idr_reg  <= s_tuser[USER_IDR];
            in_drop_reg <= s_tuser[USER_DROP];
            in_poc_reg  <= s_tdata;
            in_idx_reg  <= dec_idx_reg;
        end
        // The earliest held entry wins a tie, so only a strictly smaller POC replaces it.
        if (cmd.scan_step && (ptr_reg == '0 || rd_poc < best_poc_reg)) begin
            best_poc_reg <= rd_poc;
            best_idx_reg <= rd_idx;
            best_pos_reg <= rd_addr;
        end
        if (cmd.load_out) begin
            out_idx_reg  <= (cmd.emit_sel == SEL_NEW) ? in_idx_reg : best_idx_reg;
            out_rank_reg <= rank_reg;
            out_last_reg <= cmd.emit_last;
        end
    end

    // The store is kept oldest first: removal closes the gap, appending writes at the count.
    always_ff @(posedge aclk) begin
        if (cmd.remove_best) begin
            for (int k = 0; k < BUFFER_DEPTH - 1; k++) begin
                if (AW'(k) >= best_pos_reg) begin
                    poc_reg[k] <= poc_reg[k+1];
                    idx_reg[k] <= idx_reg[k+1];
                end
            end
        end else if (cmd.append_new) begin
            for (int k = 0; k < BUFFER_DEPTH; k++) begin
                if (count_reg == CW'(k)) begin
                    poc_reg[k] <= in_poc_reg;
                    idx_reg[k] <= in_idx_reg;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rank_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/prb_ctrl.sv =====
// Controller: sequences acceptance, drains, minimum scans, bumping and appends.
`default_nettype none

module prb_ctrl
    import prb_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire prb_stat_t stat,
    output prb_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DRAIN_CHK,
        ST_DRAIN_SCAN,
        ST_DRAIN_EMIT,
        ST_INS_CHK,
        ST_INS_SCAN,
        ST_INS_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   append_reg;
    logic   append_next;

    always_comb begin
        state_next  = state_reg;
        append_next = 1'b0;
        cmd         = '0;
        cmd.emit_sel = SEL_BEST;
        s_tready    = (state_reg == ST_IDLE) && !append_reg;

        if (append_reg) begin
            cmd.append_new = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !append_reg) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                priority if (stat.in_op) begin
                    state_next = ST_DRAIN_CHK;
                end else if (stat.in_drop) begin
                    state_next = ST_IDLE;
                end else if (stat.in_idr) begin
                    state_next = ST_DRAIN_CHK;
                end else begin
                    state_next = ST_INS_CHK;
                end
            end
            ST_DRAIN_CHK: begin
                if (stat.count_zero) begin
                    state_next = stat.in_op ? ST_IDLE : ST_INS_CHK;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_DRAIN_SCAN;
                end
            end
            ST_DRAIN_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_DRAIN_EMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DRAIN_EMIT: begin
                if (stat.out_free) begin
                    // After an IDR drain the set is empty, so the append cannot bump.
                    cmd.load_out    = 1'b1;
                    cmd.emit_last   = stat.count_one;
                    cmd.remove_best = 1'b1;
                    state_next      = ST_DRAIN_CHK;
                end
            end
            ST_INS_CHK: begin
                if (stat.count_ge_eff) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_INS_SCAN;
                end else begin
                    append_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_INS_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_INS_EMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_INS_EMIT: begin
                if (stat.out_free) begin
                    cmd.load_out  = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (stat.new_less) begin
                        cmd.emit_sel = SEL_NEW;
                    end else begin
                        cmd.remove_best = 1'b1;
                        append_next     = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            append_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            append_reg <= append_next;
        end
    end

endmodule

`default_nettype wire
